>>> rtl/core/bcpt_pkg.sv
// ----------------------------------------------------------------------------
// bcpt_pkg
// Shared types and constants for the bit context prior trainer: stream word
// layouts, item kinds and probability limits.
// ----------------------------------------------------------------------------
`default_nettype none

package bcpt_pkg;

    // Field widths fixed by the stream words
    localparam int SAMPLE_BITS = 8;
    localparam int INDEX_BITS  = 18;
    localparam int PROB_BITS   = 12;
    localparam int THR_BITS    = 32;

    // Item kinds carried on s_axis_tuser
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    // Threshold after reset and the lower probability limit
    localparam logic [THR_BITS-1:0]  THR_RESET = 32'd8;
    localparam logic [PROB_BITS-1:0] PROB_MIN  = 12'd1;

    // Input word: sample byte in the low bits, then the entry index
    typedef struct packed {
        logic [5:0]             pad;
        logic [INDEX_BITS-1:0]  entry_index;
        logic [SAMPLE_BITS-1:0] sample_byte;
    } t_s_word;

    // Result word: index, kept flag, probability, zero fill on top
    typedef struct packed {
        logic                  pad;
        logic [PROB_BITS-1:0]  probability;
        logic                  kept;
        logic [INDEX_BITS-1:0] queried_index;
    } t_m_word;

endpackage

`default_nettype wire

>>> rtl/core/bcpt_prob_div.sv
// ----------------------------------------------------------------------------
// bcpt_prob_div
// Restoring divider that forms (ones+1)*4096/(total+2) one quotient bit per
// cycle and clamps the result to the lower probability limit.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpt_prob_div
    import bcpt_pkg::*;
#(
    parameter int DW = 34
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [DW-1:0]        i_num,   // ones + 1, always below i_den
    input  wire logic [DW-1:0]        i_den,   // total + 2
    output logic                      o_done,
    output logic [PROB_BITS-1:0]      o_prob
);

    localparam int CNTW = $clog2(PROB_BITS);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_den;
    logic [PROB_BITS-1:0] r_quot;

    logic [DW-1:0]   rem2;
    logic            ge;
    logic [DW-1:0]   n_rem;

    // One restoring step: numerator low bits are zeros (scaled by 4096)
    always_comb begin
        rem2  = {r_rem[DW-2:0], 1'b0};
        ge    = (rem2 >= r_den);
        n_rem = ge ? (rem2 - r_den) : rem2;
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(PROB_BITS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[PROB_BITS-2:0], ge};
        end
    end

    // Quotient never exceeds 4095 since ones+1 < total+2; only the floor applies
    assign o_done = r_done;
    assign o_prob = (r_quot < PROB_MIN) ? PROB_MIN : r_quot;

endmodule

`default_nettype wire

>>> rtl/core/bit_context_prior_trainer.sv
// ----------------------------------------------------------------------------
// bit_context_prior_trainer
// Order-1 bitwise context counter with Laplace probability queries.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one word per item; s_axis_tuser selects the kind. A sample
//   word (tuser 0) counts the byte's eight bits into the counter memory under
//   the context {byte phase, byte four positions earlier}. A query word
//   (tuser 1) reads one entry and returns one m_axis word with the index,
//   the kept flag (total >= threshold) and the 12-bit probability of a one.
//   Samples produce no result word.
//   The threshold is written through the cfg channel (always ready); write it
//   only while the block is idle, which the block itself does not enforce.
// Sample and query steps:
//   A sample does one read-modify-write of a counter pair per bit through
//   the single read and single write port of the memory. A query does one
//   memory read, then the bit-serial division, then the output register.
//   A new item is accepted only while the block is idle.
// Reset:
//   Reset starts a clearing pass that writes one entry per cycle over all
//   PHASES*65536 entries (262144 by default); s_axis_tready stays low until
//   it ends. Threshold returns to 8, history and phase to zero.
// Stall:
//   A result waits in the output register; further samples are still taken.
//   A later query waits after its division until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_context_prior_trainer
    import bcpt_pkg::*;
#(
    parameter int PHASES      = 4,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Configuration: count_threshold
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [THR_BITS-1:0] i_cfg_data,
    // Input stream
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [31:0]         s_axis_tdata,   // [7:0] sample_byte, [25:8] entry_index
    input  wire logic                s_axis_tuser,   // [0] mode
    // Result stream
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [31:0]              m_axis_tdata    // [17:0] queried_index, [18] kept,
                                                     // [30:19] probability
);

    localparam int ENTRIES = PHASES * 65536;
    localparam int AW      = 16 + $clog2(PHASES);
    localparam int PHW     = (PHASES > 1) ? $clog2(PHASES) : 1;
    localparam int CW      = COUNT_WIDTH;
    localparam int DW      = CW + 2;
    localparam int KW      = 34;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RUN  = 3'd1;
    localparam logic [2:0] ST_QRD  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    t_s_word w_in;
    logic    accept;
    logic    out_free;
    logic [7:0] prev;

    // Control state
    logic [2:0]          r_state, n_state;
    logic [2:0]          r_cnt;
    logic [31:0]         r_hist;
    logic [PHW-1:0]      r_phase;
    logic [THR_BITS-1:0] r_thr;
    logic                r_clr_busy;
    logic [AW-1:0]       r_clr_addr;
    logic                r_upd_valid;
    logic                r_fwd_hit;
    logic                r_m_valid;

    // Payload
    logic [7:0]            r_node;
    logic [7:0]            r_shift;
    logic [PHW+7:0]        r_ctx;
    logic [AW-1:0]         r_upd_addr;
    logic                  r_upd_bit;
    logic [2*CW-1:0]       r_fwd_data;
    logic [2*CW-1:0]       r_rd_data;
    logic [INDEX_BITS-1:0] r_q_idx;
    logic                  r_q_oob;
    logic                  r_kept;
    logic [PROB_BITS-1:0]  r_prob;
    t_m_word               r_m_data;

    // Counter memory: {one count, zero count} per entry
    logic [2*CW-1:0] r_mem [ENTRIES];

    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            rd_bit;
    logic            rd_sample;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [2*CW-1:0] wr_data;

    logic [2*CW-1:0] cur;
    logic [CW-1:0]   cur_z;
    logic [CW-1:0]   cur_o;
    logic [CW-1:0]   q_z;
    logic [CW-1:0]   q_o;
    logic [CW:0]     q_total;
    logic            div_start;
    logic            div_done;
    logic [PROB_BITS-1:0] div_prob;

    assign w_in          = t_s_word'(s_axis_tdata);
    assign s_axis_tready = (r_state == ST_IDLE) && !r_clr_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign prev          = r_hist[31:24];
    assign o_cfg_ready   = 1'b1;

    // Read port: a query's entry or a sample's first bit at acceptance, the other seven bits while running
    always_comb begin
        rd_en     = 1'b0;
        rd_addr   = AW'({r_ctx, r_node});
        rd_bit    = r_shift[7];
        rd_sample = 1'b0;
        if (accept) begin
            rd_en = 1'b1;
            if (s_axis_tuser == MODE_SAMPLE) begin
                rd_addr   = AW'({r_phase, prev, 8'h01});
                rd_bit    = w_in.sample_byte[7];
                rd_sample = 1'b1;
            end else begin
                rd_addr = AW'(w_in.entry_index);
            end
        end else if (r_state == ST_RUN) begin
            rd_en     = 1'b1;
            rd_sample = 1'b1;
        end
    end

    // Merge read data with a write to the same entry in the read cycle
    assign cur   = r_fwd_hit ? r_fwd_data : r_rd_data;
    assign cur_z = cur[CW-1:0];
    assign cur_o = cur[2*CW-1:CW];

    // Write port: clearing pass first, else the counter update
    always_comb begin
        if (r_clr_busy) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = r_upd_valid;
            wr_addr = r_upd_addr;
            wr_data = cur;
            if (r_upd_bit) begin
                if (cur_o != '1) begin
                    wr_data[2*CW-1:CW] = cur_o + 1'b1;
                end
            end else begin
                if (cur_z != '1) begin
                    wr_data[CW-1:0] = cur_z + 1'b1;
                end
            end
        end
    end

    // Memory ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Query operands: an index past the table reads as zero counts
    assign q_z       = r_q_oob ? '0 : cur_z;
    assign q_o       = r_q_oob ? '0 : cur_o;
    assign q_total   = {1'b0, q_z} + {1'b0, q_o};
    assign div_start = (r_state == ST_QRD);

    bcpt_prob_div #(
        .DW(DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (DW'(q_o) + DW'(1)),
        .i_den   (DW'(q_total) + DW'(2)),
        .o_done  (div_done),
        .o_prob  (div_prob)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (s_axis_tuser == MODE_SAMPLE) ? ST_RUN : ST_QRD;
                end
            end
            ST_RUN: begin
                if (r_cnt == '0) begin
                    n_state = ST_IDLE;
                end
            end
            ST_QRD:  n_state = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_hist      <= '0;
            r_phase     <= '0;
            r_thr       <= THR_RESET;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_upd_valid <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_upd_valid <= rd_en && rd_sample;
            r_fwd_hit   <= rd_en && wr_en && (rd_addr == wr_addr);
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            // Sweep the memory once after reset
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(ENTRIES - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            // Advance history and phase per sample byte
            if (accept && s_axis_tuser == MODE_SAMPLE) begin
                r_cnt  <= 3'd6;
                r_hist <= {r_hist[23:0], w_in.sample_byte};
                if (r_phase == PHW'(PHASES - 1)) begin
                    r_phase <= '0;
                end else begin
                    r_phase <= r_phase + 1'b1;
                end
            end else if (r_state == ST_RUN) begin
                r_cnt <= r_cnt - 1'b1;
            end
            // Hold the result until taken
            if (r_state == ST_DONE && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_upd_addr <= rd_addr;
        r_upd_bit  <= rd_bit;
        r_fwd_data <= wr_data;
        if (accept) begin
            r_node  <= {6'b0, 1'b1, w_in.sample_byte[7]};
            r_shift <= {w_in.sample_byte[6:0], 1'b0};
            r_ctx   <= {r_phase, prev};
            r_q_idx <= w_in.entry_index;
            r_q_oob <= (32'(w_in.entry_index) >= 32'(ENTRIES));
        end else if (r_state == ST_RUN) begin
            r_node  <= {r_node[6:0], r_shift[7]};
            r_shift <= {r_shift[6:0], 1'b0};
        end
        if (r_state == ST_QRD) begin
            r_kept <= (KW'(q_total) >= KW'(r_thr));
        end
        if (r_state == ST_DIV && div_done) begin
            r_prob <= div_prob;
        end
        if (r_state == ST_DONE && out_free) begin
            r_m_data.pad           <= 1'b0;
            r_m_data.probability   <= r_prob;
            r_m_data.kept          <= r_kept;
            r_m_data.queried_index <= r_q_idx;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // Checks
    a_clr_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_upd_valid)
        else $error("counter update during clearing pass");

    a_clr_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !accept)
        else $error("item accepted during clearing pass");

    a_sample_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upd_valid && rd_en && rd_sample) |-> (rd_addr != r_upd_addr))
        else $error("sample read overlaps pending update of same entry");

    a_query_delivered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=> (r_m_valid && r_state == ST_IDLE))
        else $error("query result not loaded");

endmodule

`default_nettype wire
